>>> rtl/lbfs_pkg.sv
// ----------------------------------------------------------------------------
// lbfs_pkg: shared types and constants for the least-blur frame selector
// Store geometry, field widths, datapath opcodes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lbfs_pkg;

  // Store geometry
  localparam int MAX_GROUP   = 16;
  localparam int POSE_DEPTH  = 400;
  localparam int FRAME_DEPTH = 4 * MAX_GROUP + 2;
  localparam int MAX_OUT     = 4;

  // Field widths
  localparam int STAMP_W = 48;
  localparam int TAG_W   = 16;
  localparam int EXPO_W  = 27;
  localparam int RATE_W  = 16;
  localparam int GS_W    = 5;

  // Index and count widths
  localparam int FIDX_W = $clog2(FRAME_DEPTH);
  localparam int PIDX_W = $clog2(POSE_DEPTH + 1);
  localparam int KOUT_W = $clog2(MAX_OUT + 1);

  // Record widths in the stores
  localparam int FREC_W = STAMP_W + TAG_W + EXPO_W;
  localparam int PREC_W = STAMP_W + 3 * RATE_W;

  // Arithmetic widths
  localparam int ACC_W    = STAMP_W + RATE_W + 1;
  localparam int Q_W      = 17;
  localparam int STEP_W   = 5;
  localparam int SUM_W    = 32;
  localparam int E2_W     = 2 * EXPO_W;
  localparam int MPART_W  = SUM_W + EXPO_W;
  localparam int METRIC_W = SUM_W + E2_W + 1;

  // Datapath opcodes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE   = 5'd1;
  localparam logic [OP_W-1:0] OP_STORE     = 5'd2;
  localparam logic [OP_W-1:0] OP_TAKE_FB   = 5'd3;
  localparam logic [OP_W-1:0] OP_TAKE_PICK = 5'd4;
  localparam logic [OP_W-1:0] OP_GRP_INIT  = 5'd5;
  localparam logic [OP_W-1:0] OP_IMG_LOAD  = 5'd6;
  localparam logic [OP_W-1:0] OP_SRCH      = 5'd7;
  localparam logic [OP_W-1:0] OP_BAD       = 5'd8;
  localparam logic [OP_W-1:0] OP_LAT_P0    = 5'd9;
  localparam logic [OP_W-1:0] OP_LAT_P1    = 5'd10;
  localparam logic [OP_W-1:0] OP_PREP      = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_A     = 5'd12;
  localparam logic [OP_W-1:0] OP_MUL_B     = 5'd13;
  localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd14;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd15;
  localparam logic [OP_W-1:0] OP_SQ        = 5'd16;
  localparam logic [OP_W-1:0] OP_E2        = 5'd17;
  localparam logic [OP_W-1:0] OP_M_LO      = 5'd18;
  localparam logic [OP_W-1:0] OP_M_HI      = 5'd19;
  localparam logic [OP_W-1:0] OP_CMP       = 5'd20;

  // Frame store read selects
  localparam logic [1:0] FRD_HEAD  = 2'd0;
  localparam logic [1:0] FRD_LASTN = 2'd1;
  localparam logic [1:0] FRD_CUR   = 2'd2;
  localparam logic [1:0] FRD_BEST  = 2'd3;

  // Pose store read selects
  localparam logic [2:0] PRD_NEWEST = 3'd0;
  localparam logic [2:0] PRD_OLDEST = 3'd1;
  localparam logic [2:0] PRD_MID    = 3'd2;
  localparam logic [2:0] PRD_BELOW  = 3'd3;
  localparam logic [2:0] PRD_AT     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      frd_sel;
    logic [2:0]      prd_sel;
    logic            push;
    logic            push_last;
  } cmd_t;

  typedef struct packed {
    logic is_pose;
    logic want_fallback;
    logic can_pick;
    logic pose_gt_frame;
    logic frame_gt_pose;
    logic search_open;
    logic bracket_missing;
    logic bracket_bad;
    logic div_done;
    logic axis_last;
    logic group_last;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // Effective group size: zero acts as one, large values clamp
  function automatic logic [GS_W-1:0] eff_group(input logic [GS_W-1:0] gs);
    logic [GS_W-1:0] r;
    if (gs == '0) r = GS_W'(1);
    else if (gs > GS_W'(MAX_GROUP)) r = GS_W'(MAX_GROUP);
    else r = gs;
    return r;
  endfunction

endpackage

>>> rtl/lbfs_rec_if.sv
// ----------------------------------------------------------------------------
// lbfs_rec_if: record input channel
// Carries one image or pose record per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface lbfs_rec_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [lbfs_pkg::STAMP_W-1:0]        stamp_ns;
  logic [lbfs_pkg::TAG_W-1:0]          frame_tag;
  logic [lbfs_pkg::EXPO_W-1:0]         exposure_ns;
  logic signed [lbfs_pkg::RATE_W-1:0]  rate_x;
  logic signed [lbfs_pkg::RATE_W-1:0]  rate_y;
  logic signed [lbfs_pkg::RATE_W-1:0]  rate_z;

  modport source (output valid, action, stamp_ns, frame_tag, exposure_ns,
                  rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, action, stamp_ns, frame_tag, exposure_ns,
                rate_x, rate_y, rate_z, output ready);
endinterface

>>> rtl/lbfs_pick_if.sv
// ----------------------------------------------------------------------------
// lbfs_pick_if: pick output channel
// Carries one forwarded frame tag per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface lbfs_pick_if;
  logic                         valid;
  logic                         ready;
  logic [lbfs_pkg::TAG_W-1:0]   chosen_tag;
  logic                         pick_kind;
  logic                         last_of_run;

  modport source (output valid, chosen_tag, pick_kind, last_of_run, input ready);
  modport sink (input valid, chosen_tag, pick_kind, last_of_run, output ready);
endinterface

>>> rtl/least_blur_frame_selector_core.sv
// ----------------------------------------------------------------------------
// least_blur_frame_selector_core: least-blur frame selector
// Keeps image and gyro pose ring stores and forwards the least-blurred frame
// tag of each group of images once poses bracket the whole group.
// ----------------------------------------------------------------------------
// Usage:
//   records: valid/ready channel of image (action 0) or pose (action 1)
//   transactions. One record is taken at a time; ready is high only while
//   the block is idle.
//   picks: valid/ready channel of forwarded tags, up to four per record,
//   last_of_run marking the final one. A result sits in an output register.
//   cfg_we/cfg_wdata: writes group_size; write only while idle.
// Output: a result is held until work on the next one of the run begins or the
//   run ends, and is then loaded into the picks register.
// Work: an image record runs the store and any fallbacks. A pose record runs
//   the store and, per picked group, a bracket search, interpolation, a
//   bit-serial divide per axis and a metric compare for each image of the
//   group; the bit-serial divider and the pose-store binary search set the
//   time that a group takes.
// Reset: stores read as empty, group_size returns to 4, no result pending.
// Stall: while picks is stalled the sequencer waits before it takes another
//   result; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module least_blur_frame_selector_core (
  input  logic                         clk,
  input  logic                         rst,
  lbfs_rec_if.sink                     records,
  lbfs_pick_if.source                  picks,
  input  logic                         cfg_we,
  input  logic [lbfs_pkg::GS_W-1:0]    cfg_wdata
);
  import lbfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (records.valid),
    .in_ready (records.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // stores and arithmetic
  lbfs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .action      (records.action),
    .stamp_ns    (records.stamp_ns),
    .frame_tag   (records.frame_tag),
    .exposure_ns (records.exposure_ns),
    .rate_x      (records.rate_x),
    .rate_y      (records.rate_y),
    .rate_z      (records.rate_z),
    .out_valid   (picks.valid),
    .out_ready   (picks.ready),
    .out_tag     (picks.chosen_tag),
    .out_kind    (picks.pick_kind),
    .out_last    (picks.last_of_run)
  );

endmodule

>>> rtl/lbfs_ctrl.sv
// ----------------------------------------------------------------------------
// lbfs_ctrl: sequencing state machine
// Steps the datapath through store, fallback, bracket search, interpolation,
// division and metric compare, and hands results to the output register.
// ----------------------------------------------------------------------------
module lbfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output lbfs_pkg::cmd_t  cmd,
  input  lbfs_pkg::sts_t  sts
);
  import lbfs_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_STORE     = 5'd1;
  localparam logic [4:0] S_FB_CHECK  = 5'd2;
  localparam logic [4:0] S_FB_TAKE   = 5'd3;
  localparam logic [4:0] S_PK_CHECK  = 5'd4;
  localparam logic [4:0] S_PK_NEWEST = 5'd5;
  localparam logic [4:0] S_PK_OLDEST = 5'd6;
  localparam logic [4:0] S_IMG_READ  = 5'd7;
  localparam logic [4:0] S_IMG_LOAD  = 5'd8;
  localparam logic [4:0] S_SRCH      = 5'd9;
  localparam logic [4:0] S_SRCH_CMP  = 5'd10;
  localparam logic [4:0] S_BRK_P0    = 5'd11;
  localparam logic [4:0] S_BRK_P1    = 5'd12;
  localparam logic [4:0] S_BRK_CHK   = 5'd13;
  localparam logic [4:0] S_MUL_A     = 5'd14;
  localparam logic [4:0] S_MUL_B     = 5'd15;
  localparam logic [4:0] S_DIV_INIT  = 5'd16;
  localparam logic [4:0] S_DIV       = 5'd17;
  localparam logic [4:0] S_SQ        = 5'd18;
  localparam logic [4:0] S_E2        = 5'd19;
  localparam logic [4:0] S_M_LO      = 5'd20;
  localparam logic [4:0] S_M_HI      = 5'd21;
  localparam logic [4:0] S_CMP       = 5'd22;
  localparam logic [4:0] S_PK_READ   = 5'd23;
  localparam logic [4:0] S_PK_TAKE   = 5'd24;
  localparam logic [4:0] S_DONE      = 5'd25;

  logic [4:0] state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.frd_sel   = FRD_HEAD;
    cmd.prd_sel   = PRD_OLDEST;
    cmd.push      = 1'b0;
    cmd.push_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.op     = OP_STORE;
        state_next = sts.is_pose ? S_PK_CHECK : S_FB_CHECK;
      end
      // overflow fallback: flush any held result before taking a new one
      S_FB_CHECK: begin
        cmd.frd_sel = FRD_HEAD;
        if (!sts.want_fallback) begin
          state_next = S_DONE;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push   = sts.pend_valid;
          state_next = S_FB_TAKE;
        end
      end
      S_FB_TAKE: begin
        cmd.op     = OP_TAKE_FB;
        state_next = S_FB_CHECK;
      end
      // group readiness: newest pose past last image, first image past oldest pose
      S_PK_CHECK: begin
        cmd.frd_sel = FRD_LASTN;
        cmd.prd_sel = PRD_NEWEST;
        state_next  = sts.can_pick ? S_PK_NEWEST : S_DONE;
      end
      S_PK_NEWEST: begin
        cmd.frd_sel = FRD_HEAD;
        cmd.prd_sel = PRD_OLDEST;
        state_next  = sts.pose_gt_frame ? S_PK_OLDEST : S_DONE;
      end
      S_PK_OLDEST: begin
        cmd.frd_sel = FRD_HEAD;
        cmd.prd_sel = PRD_OLDEST;
        if (!sts.frame_gt_pose) begin
          state_next = S_DONE;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push   = sts.pend_valid;
          cmd.op     = OP_GRP_INIT;
          state_next = S_IMG_READ;
        end
      end
      S_IMG_READ: begin
        cmd.frd_sel = FRD_CUR;
        state_next  = S_IMG_LOAD;
      end
      S_IMG_LOAD: begin
        cmd.op     = OP_IMG_LOAD;
        state_next = S_SRCH;
      end
      // binary search for the first pose at or after the image stamp
      S_SRCH: begin
        cmd.prd_sel = PRD_MID;
        if (sts.search_open) begin
          state_next = S_SRCH_CMP;
        end else if (sts.bracket_missing) begin
          cmd.op     = OP_BAD;
          state_next = S_CMP;
        end else begin
          cmd.prd_sel = PRD_BELOW;
          state_next  = S_BRK_P0;
        end
      end
      S_SRCH_CMP: begin
        cmd.op     = OP_SRCH;
        state_next = S_SRCH;
      end
      S_BRK_P0: begin
        cmd.op      = OP_LAT_P0;
        cmd.prd_sel = PRD_AT;
        state_next  = S_BRK_P1;
      end
      S_BRK_P1: begin
        cmd.op     = OP_LAT_P1;
        state_next = S_BRK_CHK;
      end
      S_BRK_CHK: begin
        if (sts.bracket_bad) begin
          cmd.op     = OP_BAD;
          state_next = S_CMP;
        end else begin
          cmd.op     = OP_PREP;
          state_next = S_MUL_A;
        end
      end
      // per axis: interpolate, divide, square
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = sts.axis_last ? S_E2 : S_MUL_A;
      end
      S_E2: begin
        cmd.op     = OP_E2;
        state_next = S_M_LO;
      end
      S_M_LO: begin
        cmd.op     = OP_M_LO;
        state_next = S_M_HI;
      end
      S_M_HI: begin
        cmd.op     = OP_M_HI;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op     = OP_CMP;
        state_next = sts.group_last ? S_PK_READ : S_IMG_READ;
      end
      S_PK_READ: begin
        cmd.frd_sel = FRD_BEST;
        state_next  = S_PK_TAKE;
      end
      S_PK_TAKE: begin
        cmd.op     = OP_TAKE_PICK;
        state_next = S_PK_CHECK;
      end
      // release the held result as the last of this run
      S_DONE: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lbfs_dp.sv
// ----------------------------------------------------------------------------
// lbfs_dp: selector datapath
// Frame and pose ring stores, search bounds, interpolation multiplier,
// bit-serial rounding divider, metric build, best tracking, output register.
// ----------------------------------------------------------------------------
module lbfs_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lbfs_pkg::cmd_t                       cmd,
  output lbfs_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [lbfs_pkg::GS_W-1:0]            cfg_wdata,
  input  logic                                 action,
  input  logic [lbfs_pkg::STAMP_W-1:0]         stamp_ns,
  input  logic [lbfs_pkg::TAG_W-1:0]           frame_tag,
  input  logic [lbfs_pkg::EXPO_W-1:0]          exposure_ns,
  input  logic signed [lbfs_pkg::RATE_W-1:0]   rate_x,
  input  logic signed [lbfs_pkg::RATE_W-1:0]   rate_y,
  input  logic signed [lbfs_pkg::RATE_W-1:0]   rate_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lbfs_pkg::TAG_W-1:0]           out_tag,
  output logic                                 out_kind,
  output logic                                 out_last
);
  import lbfs_pkg::*;

  // ring index helpers
  function automatic logic [FIDX_W-1:0] fidx(input logic [FIDX_W-1:0] h,
                                             input logic [FIDX_W-1:0] o);
    logic [FIDX_W:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= (FIDX_W+1)'(FRAME_DEPTH)) s = s - (FIDX_W+1)'(FRAME_DEPTH);
    return s[FIDX_W-1:0];
  endfunction

  function automatic logic [PIDX_W-1:0] pidx(input logic [PIDX_W-1:0] h,
                                             input logic [PIDX_W-1:0] o);
    logic [PIDX_W:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= (PIDX_W+1)'(POSE_DEPTH)) s = s - (PIDX_W+1)'(POSE_DEPTH);
    return s[PIDX_W-1:0];
  endfunction

  // control state
  logic [GS_W-1:0]   group_size;
  logic [FIDX_W-1:0] fhead, fcount;
  logic [PIDX_W-1:0] phead, pcount;
  logic [KOUT_W-1:0] k;
  logic              pend_valid;

  // payload state
  logic                      is_pose;
  logic [STAMP_W-1:0]        c_stamp;
  logic [TAG_W-1:0]          c_tag;
  logic [EXPO_W-1:0]         c_expo;
  logic signed [RATE_W-1:0]  c_rate [3];
  logic [TAG_W-1:0]          pend_tag;
  logic                      pend_kind;
  logic [GS_W-1:0]           i, best;
  logic [METRIC_W-1:0]       best_metric, metric;
  logic [STAMP_W-1:0]        fs, t0, t1, dt, w0, w1;
  logic [EXPO_W-1:0]         fe;
  logic [PIDX_W-1:0]         a, b;
  logic signed [RATE_W-1:0]  v0 [3];
  logic signed [RATE_W-1:0]  v1 [3];
  logic [1:0]                axis;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          rem;
  logic [Q_W-1:0]            q;
  logic [STEP_W-1:0]         step;
  logic [SUM_W-1:0]          sum;
  logic [E2_W-1:0]           e2;

  // stores and their registered read data
  logic [FREC_W-1:0] fmem [FRAME_DEPTH];
  logic [PREC_W-1:0] pmem [POSE_DEPTH];
  logic [FREC_W-1:0] frd;
  logic [PREC_W-1:0] prd;

  logic [GS_W-1:0]   n;
  logic [FIDX_W-1:0] foff, fra, fwa;
  logic [PIDX_W-1:0] poff, pra, pwa, m;
  logic              fwe, pwe;
  logic [STAMP_W-1:0] f_stamp, p_stamp;
  logic [TAG_W-1:0]   f_tag;
  logic [EXPO_W-1:0]  f_expo;

  logic signed [RATE_W-1:0] vsel;
  logic [STAMP_W-1:0]       wsel;
  logic signed [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]         mag, dsh;
  logic [MPART_W-1:0]       mpart;
  logic [2*Q_W-1:0]         qsq;

  assign n = eff_group(group_size);

  assign f_stamp = frd[FREC_W-1 -: STAMP_W];
  assign f_tag   = frd[EXPO_W +: TAG_W];
  assign f_expo  = frd[EXPO_W-1:0];
  assign p_stamp = prd[PREC_W-1 -: STAMP_W];

  // read address selection
  assign m = a + ((b - a) >> 1);

  always_comb begin
    case (cmd.frd_sel)
      FRD_HEAD:  foff = '0;
      FRD_LASTN: foff = FIDX_W'(n) - FIDX_W'(1);
      FRD_CUR:   foff = FIDX_W'(i);
      FRD_BEST:  foff = FIDX_W'(best);
      default:   foff = '0;
    endcase
    case (cmd.prd_sel)
      PRD_NEWEST: poff = pcount - PIDX_W'(1);
      PRD_OLDEST: poff = '0;
      PRD_MID:    poff = m;
      PRD_BELOW:  poff = a - PIDX_W'(1);
      PRD_AT:     poff = a;
      default:    poff = '0;
    endcase
  end

  assign fra = fidx(fhead, foff);
  assign pra = pidx(phead, poff);
  assign fwa = fidx(fhead, fcount);
  assign pwa = (pcount < PIDX_W'(POSE_DEPTH)) ? pidx(phead, pcount) : phead;
  assign fwe = (cmd.op == OP_STORE) && !is_pose && (fcount < FIDX_W'(FRAME_DEPTH));
  assign pwe = (cmd.op == OP_STORE) && is_pose;

  // frame store
  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= {c_stamp, c_tag, c_expo};
    frd <= fmem[fra];
  end

  // pose store
  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= {c_stamp, c_rate[0], c_rate[1], c_rate[2]};
    prd <= pmem[pra];
  end

  // shared arithmetic
  assign vsel  = (cmd.op == OP_MUL_A) ? v0[axis] : v1[axis];
  assign wsel  = (cmd.op == OP_MUL_A) ? w0 : w1;
  assign prod  = $signed({1'b0, wsel}) * vsel;
  assign mag   = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
  assign dsh   = ACC_W'(dt) << step;
  assign mpart = sum * ((cmd.op == OP_M_HI) ? e2[E2_W-1:EXPO_W] : e2[EXPO_W-1:0]);
  assign qsq   = q * q;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GS_W'(4);
      fhead      <= '0;
      fcount     <= '0;
      phead      <= '0;
      pcount     <= '0;
      k          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) group_size <= cfg_wdata;
      if (cmd.push) pend_valid <= 1'b0;
      case (cmd.op)
        OP_CAPTURE: k <= '0;
        OP_STORE: begin
          if (is_pose) begin
            if (pcount < PIDX_W'(POSE_DEPTH)) pcount <= pcount + PIDX_W'(1);
            else phead <= pidx(phead, PIDX_W'(1));
          end else if (fcount < FIDX_W'(FRAME_DEPTH)) begin
            fcount <= fcount + FIDX_W'(1);
          end
        end
        OP_TAKE_FB, OP_TAKE_PICK: begin
          k          <= k + KOUT_W'(1);
          pend_valid <= 1'b1;
          fhead      <= fidx(fhead, FIDX_W'(n));
          fcount     <= fcount - FIDX_W'(n);
        end
        default: ;
      endcase
      if (cmd.push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_tag  <= pend_tag;
      out_kind <= pend_kind;
      out_last <= cmd.push_last;
    end
    case (cmd.op)
      OP_CAPTURE: begin
        is_pose   <= action;
        c_stamp   <= stamp_ns;
        c_tag     <= frame_tag;
        c_expo    <= exposure_ns;
        c_rate[0] <= rate_x;
        c_rate[1] <= rate_y;
        c_rate[2] <= rate_z;
      end
      OP_TAKE_FB: begin
        pend_tag  <= f_tag;
        pend_kind <= 1'b1;
      end
      OP_TAKE_PICK: begin
        pend_tag  <= f_tag;
        pend_kind <= 1'b0;
      end
      OP_GRP_INIT: begin
        i           <= '0;
        best        <= '0;
        best_metric <= '1;
      end
      OP_IMG_LOAD: begin
        fs <= f_stamp;
        fe <= f_expo;
        a  <= '0;
        b  <= pcount;
      end
      OP_SRCH: begin
        if (p_stamp < fs) a <= m + PIDX_W'(1);
        else b <= m;
      end
      OP_BAD: metric <= '1;
      OP_LAT_P0: begin
        t0    <= p_stamp;
        v0[0] <= prd[3*RATE_W-1 -: RATE_W];
        v0[1] <= prd[2*RATE_W-1 -: RATE_W];
        v0[2] <= prd[RATE_W-1:0];
      end
      OP_LAT_P1: begin
        t1    <= p_stamp;
        v1[0] <= prd[3*RATE_W-1 -: RATE_W];
        v1[1] <= prd[2*RATE_W-1 -: RATE_W];
        v1[2] <= prd[RATE_W-1:0];
      end
      OP_PREP: begin
        dt   <= t1 - t0;
        w0   <= t1 - fs;
        w1   <= fs - t0;
        axis <= '0;
        sum  <= '0;
      end
      OP_MUL_A: acc <= prod;
      OP_MUL_B: acc <= acc + prod;
      // round to nearest: add half the divisor before dividing
      OP_DIV_INIT: begin
        rem  <= mag + ACC_W'(dt >> 1);
        q    <= '0;
        step <= STEP_W'(Q_W - 1);
      end
      OP_DIV_STEP: begin
        if (rem >= dsh) begin
          rem     <= rem - dsh;
          q[step] <= 1'b1;
        end
        step <= step - STEP_W'(1);
      end
      OP_SQ: begin
        sum  <= sum + qsq[SUM_W-1:0];
        axis <= axis + 2'd1;
      end
      OP_E2:   e2 <= fe * fe;
      OP_M_LO: metric <= METRIC_W'(mpart);
      OP_M_HI: metric <= metric + (METRIC_W'(mpart) << EXPO_W);
      OP_CMP: begin
        if (metric < best_metric) begin
          best        <= i;
          best_metric <= metric;
        end
        i <= i + GS_W'(1);
      end
      default: ;
    endcase
  end

  // status to the controller
  assign sts.is_pose         = is_pose;
  assign sts.want_fallback   = (k < KOUT_W'(MAX_OUT)) &&
                               (fcount > ({n, 2'b00} + FIDX_W'(1)));
  assign sts.can_pick        = (k < KOUT_W'(MAX_OUT)) && (fcount >= FIDX_W'(n)) &&
                               (pcount != '0);
  assign sts.pose_gt_frame   = p_stamp > f_stamp;
  assign sts.frame_gt_pose   = f_stamp > p_stamp;
  assign sts.search_open     = a < b;
  assign sts.bracket_missing = (a == '0) || (a >= pcount);
  assign sts.bracket_bad     = (t1 <= t0) || (fs < t0) || (fs > t1);
  assign sts.div_done        = (step == '0);
  assign sts.axis_last       = (axis == 2'd2);
  assign sts.group_last      = (i == n - GS_W'(1));
  assign sts.pend_valid      = pend_valid;
  assign sts.out_free        = !out_valid || out_ready;

endmodule
